[sv/ttq_pkg.sv]
// Shared constants, register codes and types of the threshold table quantizer.
package ttq_pkg;

	localparam int unsigned MAX_BITS_DEF     = 12;
	localparam int unsigned SAMPLE_WIDTH_DEF = 24;

	localparam int unsigned MODE_W    = 2;
	localparam int unsigned BITS_W    = 4;
	localparam int unsigned VREF_W    = 23;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 23;
	localparam int unsigned BITS_MIN  = 4;

	localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WR_TH  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WR_LV  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BITS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TWOS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VREF     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_EN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_TOL = 3'd4;

	localparam logic [BITS_W-1:0] BITS_RST     = 4'd8;
	localparam logic              TWOS_RST     = 1'b0;
	localparam logic [VREF_W-1:0] VREF_RST     = 23'd4194304;
	localparam logic              SNAP_EN_RST  = 1'b1;
	localparam logic [VREF_W-1:0] SNAP_TOL_RST = 23'd164;

	typedef struct packed {
		logic [BITS_W-1:0] bits;
		logic              twos;
		logic [VREF_W-1:0] vref;
		logic              snap_en;
		logic [VREF_W-1:0] snap_tol;
	} cfg_regs_t;

endpackage

[sv/ttq_ifs.sv]
// Handshake interfaces for the input, result and configuration channels.
interface ttq_in_if #(
	parameter int unsigned IDX_W = ttq_pkg::MAX_BITS_DEF + 1,
	parameter int unsigned VAL_W = ttq_pkg::SAMPLE_WIDTH_DEF
);
	import ttq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic [IDX_W-1:0]         index;
	logic signed [VAL_W-1:0]  value;

	modport source (output valid, mode, index, value, input ready);
	modport sink (input valid, mode, index, value, output ready);
endinterface

interface ttq_out_if #(
	parameter int unsigned CODE_W = ttq_pkg::MAX_BITS_DEF + 1,
	parameter int unsigned VAL_W  = ttq_pkg::SAMPLE_WIDTH_DEF
);
	logic                     valid;
	logic                     ready;
	logic signed [CODE_W-1:0] code;
	logic signed [VAL_W-1:0]  level;

	modport source (output valid, code, level, input ready);
	modport sink (input valid, code, level, output ready);
endinterface

interface ttq_cfg_if;
	import ttq_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/ttq_ram.sv]
// Generic RAM with one write port and one registered read port.
module ttq_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/ttq_cfg_regs.sv]
// Configuration register file of the quantizer.
module ttq_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	ttq_cfg_if.sink           cfg,
	output ttq_pkg::cfg_regs_t regs,
	output logic              bits_wr
);
	import ttq_pkg::*;

	cfg_regs_t regs_q;
	logic      wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;
	assign bits_wr   = wr && (cfg.index == REG_BITS);
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.bits     <= BITS_RST;
			regs_q.twos     <= TWOS_RST;
			regs_q.vref     <= VREF_RST;
			regs_q.snap_en  <= SNAP_EN_RST;
			regs_q.snap_tol <= SNAP_TOL_RST;
		end else if (wr) begin
			case (cfg.index)
				REG_BITS:     regs_q.bits     <= cfg.data[BITS_W-1:0];
				REG_TWOS:     regs_q.twos     <= cfg.data[0];
				REG_VREF:     regs_q.vref     <= cfg.data[VREF_W-1:0];
				REG_SNAP_EN:  regs_q.snap_en  <= cfg.data[0];
				REG_SNAP_TOL: regs_q.snap_tol <= cfg.data[VREF_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

[sv/threshold_table_quantizer_core.sv]
// Threshold table quantizer: table loading, clipping, edge snapping and binary search.
//
//   channel  dir  payload                      accepted when
//   item     in   mode, index, value           item.valid && item.ready
//   result   out  code, level                  result.valid && result.ready
//   cfg      in   index, data                  cfg.valid && cfg.ready (always ready)
//
// A sample word on a nondecreasing table makes one threshold memory read per binary
// search step, once for the snap search over entries 1..2^bits-1 and once for the
// code search over 0..2^bits. The first sample with snapping on after a threshold
// write, or a bits write taken while idle, first sweeps entries 1..2^bits-1 to learn
// whether they are sorted; on an unsorted table the snap search is a linear scan of
// up to 2^bits-1 reads. Reset clears control state and the result register only;
// tables are undefined until written. A stalled result holds in the output register
// and the block waits in its last step until that register frees.
module threshold_table_quantizer_core #(
	parameter int unsigned MAX_BITS     = ttq_pkg::MAX_BITS_DEF,
	parameter int unsigned SAMPLE_WIDTH = ttq_pkg::SAMPLE_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ttq_in_if.sink    item,
	ttq_out_if.source result,
	ttq_cfg_if.sink   cfg
);
	import ttq_pkg::*;

	localparam int unsigned IDX_W    = MAX_BITS + 1;
	localparam int unsigned CODE_W   = MAX_BITS + 1;
	localparam int unsigned CW       = MAX_BITS + 2;
	localparam int unsigned TH_DEPTH = (1 << MAX_BITS) + 1;
	localparam int unsigned LV_DEPTH = 1 << MAX_BITS;
	localparam int unsigned CMP_W    =
		((SAMPLE_WIDTH > VREF_W + 1) ? SAMPLE_WIDTH : VREF_W + 1) + 1;
	localparam logic [CW-1:0] TOP_IDX = CW'(LV_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_SNAP_BS, S_SNAP_TH, S_SNAP_LIN, S_TH0, S_THN, S_MAIN, S_LVL
	} state_t;

	cfg_regs_t regs;
	logic      bits_wr;

	state_t state_q, state_d;
	logic   sorted_vld_q, sorted_vld_d;
	logic   sorted_q, sorted_d;
	logic   ok_q, ok_d;
	logic   out_vld_q, out_vld_d;

	logic signed [SAMPLE_WIDTH-1:0] x_q, x_d;
	logic signed [SAMPLE_WIDTH-1:0] prev_q, prev_d;
	logic [CW-1:0] n_q, n_d;
	logic [CW-1:0] first_q, first_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] mid_q, mid_d;
	logic [CW-1:0] code_q, code_d;
	logic signed [CODE_W-1:0]       out_code_q, out_code_d;
	logic signed [SAMPLE_WIDTH-1:0] out_level_q, out_level_d;

	logic                    acc;
	logic                    th_we;
	logic                    lv_we;
	logic [SAMPLE_WIDTH-1:0] th_rdata;
	logic [SAMPLE_WIDTH-1:0] lv_rdata;

	logic [BITS_W-1:0] b_sat;
	logic [CW-1:0]     n_cfg;
	logic signed [CMP_W-1:0] xe, the, prev_e, vre, tole, diff, ve, clipv;
	logic              lt;
	logic              in_tol;
	logic [CW-1:0]     half;
	logic [CW-1:0]     f1;
	logic [CW-1:0]     c1;
	logic [CW-1:0]     cand;
	logic              ok_now;

	ttq_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.regs    (regs),
		.bits_wr (bits_wr)
	);

	assign item.ready = (state_q == S_IDLE);
	assign acc        = item.valid && item.ready;
	assign th_we      = acc && (item.mode == MODE_WR_TH) && (CW'(item.index) <= TOP_IDX);
	assign lv_we      = acc && (item.mode == MODE_WR_LV) && !item.index[MAX_BITS];

	ttq_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(TH_DEPTH)) u_th_ram (
		.clk   (clk),
		.we    (th_we),
		.waddr (item.index),
		.wdata (item.value),
		.raddr (mid_d[IDX_W-1:0]),
		.rdata (th_rdata)
	);

	ttq_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(LV_DEPTH)) u_lv_ram (
		.clk   (clk),
		.we    (lv_we),
		.waddr (item.index[MAX_BITS-1:0]),
		.wdata (item.value),
		.raddr (code_d[MAX_BITS-1:0]),
		.rdata (lv_rdata)
	);

	assign result.valid = out_vld_q;
	assign result.code  = out_code_q;
	assign result.level = out_level_q;

	// Resolution saturated to the supported range.
	always_comb begin
		if (int'(regs.bits) < BITS_MIN) begin
			b_sat = BITS_W'(BITS_MIN);
		end else if (int'(regs.bits) > MAX_BITS) begin
			b_sat = BITS_W'(MAX_BITS);
		end else begin
			b_sat = regs.bits;
		end
		n_cfg = CW'(1) << b_sat;
	end

	// Shared compare unit: the sample against the threshold read back this cycle.
	assign xe     = CMP_W'(x_q);
	assign the    = CMP_W'($signed(th_rdata));
	assign prev_e = CMP_W'(prev_q);
	assign vre    = $signed(CMP_W'(regs.vref));
	assign tole   = $signed(CMP_W'(regs.snap_tol));
	assign ve     = CMP_W'(item.value);
	assign lt     = xe < the;
	assign diff   = the - xe;
	assign in_tol = diff <= tole;

	// One upper-bound search step on the entry at mid_q.
	always_comb begin
		half = count_q >> 1;
		if (!lt) begin
			f1 = mid_q + CW'(1);
			c1 = count_q - half - CW'(1);
		end else begin
			f1 = first_q;
			c1 = half;
		end
	end

	always_comb begin
		if (ve < -vre) begin
			clipv = -vre;
		end else if (ve > vre) begin
			clipv = vre;
		end else begin
			clipv = ve;
		end
	end

	assign ok_now = (mid_q == CW'(1)) ? 1'b1 : (ok_q && !(the < prev_e));

	always_comb begin
		state_d      = state_q;
		sorted_vld_d = sorted_vld_q;
		sorted_d     = sorted_q;
		ok_d         = ok_q;
		out_vld_d    = out_vld_q;
		x_d          = x_q;
		prev_d       = prev_q;
		n_d          = n_q;
		first_d      = first_q;
		count_d      = count_q;
		mid_d        = mid_q;
		code_d       = code_q;
		out_code_d   = out_code_q;
		out_level_d  = out_level_q;
		cand         = '0;

		if (out_vld_q && result.ready) begin
			out_vld_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (th_we || bits_wr) begin
					sorted_vld_d = 1'b0;
				end
				if (acc && (item.mode == MODE_SAMPLE)) begin
					x_d = SAMPLE_WIDTH'(clipv);
					n_d = n_cfg;
					if (!regs.snap_en) begin
						state_d = S_TH0;
						mid_d   = '0;
					end else if (!sorted_vld_q) begin
						state_d = S_CHK;
						mid_d   = CW'(1);
					end else if (sorted_q) begin
						state_d = S_SNAP_BS;
						first_d = CW'(1);
						count_d = n_cfg - CW'(1);
						mid_d   = CW'(1) + ((n_cfg - CW'(1)) >> 1);
					end else begin
						state_d = S_SNAP_LIN;
						mid_d   = CW'(1);
					end
				end
			end
			S_CHK: begin
				ok_d   = ok_now;
				prev_d = SAMPLE_WIDTH'(the);
				if (mid_q == n_q - CW'(1)) begin
					sorted_vld_d = 1'b1;
					sorted_d     = ok_now;
					if (ok_now) begin
						state_d = S_SNAP_BS;
						first_d = CW'(1);
						count_d = n_q - CW'(1);
						mid_d   = CW'(1) + ((n_q - CW'(1)) >> 1);
					end else begin
						state_d = S_SNAP_LIN;
						mid_d   = CW'(1);
					end
				end else begin
					mid_d = mid_q + CW'(1);
				end
			end
			S_SNAP_BS: begin
				if (c1 == '0) begin
					if (f1 < n_q) begin
						state_d = S_SNAP_TH;
						mid_d   = f1;
					end else begin
						state_d = S_TH0;
						mid_d   = '0;
					end
				end else begin
					first_d = f1;
					count_d = c1;
					mid_d   = f1 + (c1 >> 1);
				end
			end
			S_SNAP_TH: begin
				if (lt && in_tol) begin
					x_d = SAMPLE_WIDTH'(the);
				end
				state_d = S_TH0;
				mid_d   = '0;
			end
			S_SNAP_LIN: begin
				if (lt) begin
					if (in_tol) begin
						x_d = SAMPLE_WIDTH'(the);
					end
					state_d = S_TH0;
					mid_d   = '0;
				end else if (mid_q == n_q - CW'(1)) begin
					state_d = S_TH0;
					mid_d   = '0;
				end else begin
					mid_d = mid_q + CW'(1);
				end
			end
			S_TH0: begin
				if (xe <= the) begin
					state_d = S_LVL;
					code_d  = '0;
				end else begin
					state_d = S_THN;
					mid_d   = n_q;
				end
			end
			S_THN: begin
				if (!lt) begin
					state_d = S_LVL;
					code_d  = n_q - CW'(1);
				end else begin
					state_d = S_MAIN;
					first_d = '0;
					count_d = n_q + CW'(1);
					mid_d   = (n_q + CW'(1)) >> 1;
				end
			end
			S_MAIN: begin
				if (c1 == '0) begin
					cand = (f1 == '0) ? '0 : f1 - CW'(1);
					if (cand > n_q - CW'(1)) begin
						cand = n_q - CW'(1);
					end
					state_d = S_LVL;
					code_d  = cand;
				end else begin
					first_d = f1;
					count_d = c1;
					mid_d   = f1 + (c1 >> 1);
				end
			end
			S_LVL: begin
				// The level read for code_q is held until the output register frees.
				if (!out_vld_q || result.ready) begin
					out_vld_d   = 1'b1;
					out_level_d = $signed(lv_rdata);
					if (regs.twos) begin
						out_code_d = $signed(CODE_W'(code_q) - CODE_W'(n_q >> 1));
					end else begin
						out_code_d = $signed(CODE_W'(code_q));
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sorted_vld_q <= 1'b0;
			sorted_q     <= 1'b0;
			ok_q         <= 1'b0;
			out_vld_q    <= 1'b0;
			out_code_q   <= '0;
			out_level_q  <= '0;
		end else begin
			state_q      <= state_d;
			sorted_vld_q <= sorted_vld_d;
			sorted_q     <= sorted_d;
			ok_q         <= ok_d;
			out_vld_q    <= out_vld_d;
			out_code_q   <= out_code_d;
			out_level_q  <= out_level_d;
		end
	end

	always_ff @(posedge clk) begin
		x_q         <= x_d;
		prev_q      <= prev_d;
		n_q         <= n_d;
		first_q     <= first_d;
		count_q     <= count_d;
		mid_q       <= mid_d;
		code_q      <= code_d;
	end
endmodule

[sim/ttq_quant_checker.sv]
// Checker that mirrors the quantizer from the observed words and compares every result.
module ttq_quant_checker (
	input  logic clk,
	input  logic arst_n,
	ttq_in_if    item,
	ttq_out_if   result,
	ttq_cfg_if   cfg,
	output int   bad_words,
	output int   codes_waiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import ttq_pkg::*;

	localparam int unsigned TH_DEPTH = (1 << MAX_BITS_DEF) + 1;
	localparam int unsigned LV_DEPTH = 1 << MAX_BITS_DEF;
	localparam int unsigned CODE_W   = MAX_BITS_DEF + 1;
	localparam int unsigned VAL_W    = SAMPLE_WIDTH_DEF;

	typedef struct packed {
		logic signed [CODE_W-1:0] code;
		logic signed [VAL_W-1:0]  level;
	} quant_word_t;

	logic signed [VAL_W-1:0] th_mem [TH_DEPTH];
	logic signed [VAL_W-1:0] lv_mem [LV_DEPTH];
	cfg_regs_t               regs;
	quant_word_t             codes_due [$];
	int                      fails;

	function automatic quant_word_t quantize_sample(logic signed [VAL_W-1:0] sample);
		int unsigned res_bits, n, k, lo, span, half, mid, pick;
		longint      x, lim;
		int          signed_code;
		quant_word_t w;
		res_bits = regs.bits;
		if (res_bits < BITS_MIN)
			res_bits = BITS_MIN;
		if (res_bits > MAX_BITS_DEF)
			res_bits = MAX_BITS_DEF;
		n = 1 << res_bits;
		lim = longint'(regs.vref);
		x = sample;
		if (x < -lim)
			x = -lim;
		if (x > lim)
			x = lim;
		// Snapping looks only at the first threshold above the clipped sample.
		if (regs.snap_en) begin
			for (k = 1; k < n; k++) begin
				if (x < th_mem[k]) begin
					if (th_mem[k] - x <= longint'(regs.snap_tol))
						x = th_mem[k];
					break;
				end
			end
		end
		if (x <= th_mem[0]) begin
			pick = 0;
		end else if (x >= th_mem[n]) begin
			pick = n - 1;
		end else begin
			lo = 0;
			span = n + 1;
			while (span > 0) begin
				half = span >> 1;
				mid = lo + half;
				if (!(x < th_mem[mid])) begin
					lo = mid + 1;
					span = span - half - 1;
				end else begin
					span = half;
				end
			end
			pick = (lo == 0) ? 0 : lo - 1;
			if (pick > n - 1)
				pick = n - 1;
		end
		signed_code = regs.twos ? int'(pick) - int'(n >> 1) : int'(pick);
		w.code = signed_code[CODE_W-1:0];
		w.level = lv_mem[pick];
		return w;
	endfunction

	task automatic flag(input string msg);
		fails++;
		if (fails <= 10)
			$display("%t checker: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		quant_word_t got, want;
		if (!arst_n) begin
			regs = '{bits: BITS_RST, twos: TWOS_RST, vref: VREF_RST,
				snap_en: SNAP_EN_RST, snap_tol: SNAP_TOL_RST};
			codes_due.delete();
			codes_waiting <= 0;
		end else begin
			if (result.valid && result.ready) begin
				got.code = result.code;
				got.level = result.level;
				if (codes_due.size() == 0) begin
					flag($sformatf("unexpected result word code %0d level %0d",
						got.code, got.level));
				end else begin
					want = codes_due.pop_front();
					if (got.code !== want.code)
						flag($sformatf("code expected %0d got %0d", want.code, got.code));
					if (got.level !== want.level)
						flag($sformatf("level expected %0d got %0d (code %0d)",
							want.level, got.level, want.code));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_BITS:     regs.bits = cfg.data[BITS_W-1:0];
					REG_TWOS:     regs.twos = cfg.data[0];
					REG_VREF:     regs.vref = cfg.data[VREF_W-1:0];
					REG_SNAP_EN:  regs.snap_en = cfg.data[0];
					REG_SNAP_TOL: regs.snap_tol = cfg.data[VREF_W-1:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				case (item.mode)
					MODE_SAMPLE: codes_due.push_back(quantize_sample(item.value));
					MODE_WR_TH: begin
						if (item.index < TH_DEPTH)
							th_mem[item.index] = item.value;
					end
					MODE_WR_LV: begin
						if (item.index < LV_DEPTH)
							lv_mem[item.index] = item.value;
					end
					default: ;
				endcase
			end
			codes_waiting <= codes_due.size();
		end
		bad_words <= fails;
	end

endmodule

[sim/threshold_table_quantizer_core_tb.sv]
// Top of the quantizer testbench: clock, reset, table loads, samples and the verdict.
module threshold_table_quantizer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ttq_pkg::*;

	typedef enum int { SHAPE_UNIFORM, SHAPE_RAGGED, SHAPE_SCRAMBLED } table_shape_t;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int     TH_LAST        = 1 << MAX_BITS_DEF;
	localparam int     IDX_TOP        = (1 << (MAX_BITS_DEF + 1)) - 1;
	localparam longint VAL_MIN        = -(longint'(1) << (SAMPLE_WIDTH_DEF - 1));
	localparam longint VAL_MAX        = (longint'(1) << (SAMPLE_WIDTH_DEF - 1)) - 1;
	localparam int     SETTLE_CYCLES  = 64;
	localparam int     WATCHDOG_LIMIT = 50000;

	logic   clk;
	logic   arst_n;
	bit     calm;
	int     bad_words;
	int     codes_waiting;
	int     quiet_cycles;
	int     n_codes;
	longint vref_now;
	longint tol_now;
	logic signed [SAMPLE_WIDTH_DEF-1:0] th_shadow [TH_LAST + 1];

	ttq_in_if  item_ch ();
	ttq_out_if res_ch ();
	ttq_cfg_if cfg_ch ();

	threshold_table_quantizer_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	ttq_quant_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item_ch),
		.result        (res_ch),
		.cfg           (cfg_ch),
		.bad_words     (bad_words),
		.codes_waiting (codes_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [SAMPLE_WIDTH_DEF-1:0] fit24(longint v);
		if (v < VAL_MIN)
			v = VAL_MIN;
		if (v > VAL_MAX)
			v = VAL_MAX;
		return v[SAMPLE_WIDTH_DEF-1:0];
	endfunction

	function automatic longint rand24();
		return longint'($urandom_range(0, (1 << SAMPLE_WIDTH_DEF) - 1)) + VAL_MIN;
	endfunction

	function automatic longint pick_sample();
		longint d, th;
		th = th_shadow[$urandom_range(0, n_codes)];
		case ($urandom_range(0, 7))
			0, 1, 2: begin
				// Land on, just inside and just outside the snap window of a threshold.
				case ($urandom_range(0, 4))
					0: d = 0;
					1: d = tol_now;
					2: d = tol_now + 1;
					3: d = longint'($urandom_range(0, tol_now + 1));
					default: d = -1;
				endcase
				return th - d;
			end
			3, 4: return longint'($urandom_range(0, 2 * vref_now)) - vref_now;
			5: return ($urandom_range(0, 1) ? 1 : -1) * (vref_now + longint'($urandom_range(0, 1000)));
			default: return rand24();
		endcase
	endfunction

	task automatic send_word(input logic [MODE_W-1:0] m, input int idx, input longint v);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.mode <= m;
		item_ch.index <= idx[MAX_BITS_DEF:0];
		item_ch.value <= fit24(v);
		if (m == MODE_WR_TH && idx <= TH_LAST)
			th_shadow[idx] = fit24(v);
		do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
		if ($urandom_range(0, 59) == 0)
			calm = !calm;
	endtask

	// Holds the sender back until every result is out, then lets the block settle.
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (codes_waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] r, input longint d);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data <= d[CFG_DAT_W-1:0];
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic configure(input int bits_reg, input int twos, input longint vr,
			input int snap, input longint tol, input table_shape_t shape);
		longint acc, step;
		int     k, res_bits;
		cfg_write(REG_BITS, bits_reg);
		cfg_write(REG_TWOS, twos);
		cfg_write(REG_VREF, vr);
		cfg_write(REG_SNAP_EN, snap);
		cfg_write(REG_SNAP_TOL, tol);
		res_bits = bits_reg < BITS_MIN ? BITS_MIN : bits_reg > MAX_BITS_DEF ? MAX_BITS_DEF : bits_reg;
		n_codes = 1 << res_bits;
		vref_now = vr;
		tol_now = tol;
		step = (2 * vref_now) / n_codes;
		if (step < 1)
			step = 1;
		acc = -vref_now - longint'($urandom_range(0, 1000));
		// Every entry the next samples can touch is written before any sample.
		for (k = 0; k <= n_codes; k++) begin
			case (shape)
				SHAPE_UNIFORM:
					send_word(MODE_WR_TH, k, -vref_now + (2 * vref_now * longint'(k)) / n_codes);
				SHAPE_RAGGED: begin
					send_word(MODE_WR_TH, k, acc);
					if ($urandom_range(0, 7) != 0)
						acc = acc + longint'($urandom_range(0, 2 * step));
				end
				default:
					send_word(MODE_WR_TH, k, $urandom_range(0, 1) ? rand24() :
						longint'($urandom_range(0, 2 * vref_now)) - vref_now);
			endcase
		end
		for (k = 0; k < n_codes; k++)
			send_word(MODE_WR_LV, k, rand24());
	endtask

	task automatic random_words(input int samples, input bit churn);
		int done, r, idx;
		done = 0;
		while (done < samples) begin
			r = $urandom_range(0, 99);
			if (churn && r < 10) begin
				idx = $urandom_range(0, n_codes);
				send_word(MODE_WR_TH, idx, $urandom_range(0, 1) ? rand24() :
					longint'(th_shadow[idx]) + longint'($urandom_range(0, 2000)) - 1000);
			end else if (churn && r < 18) begin
				send_word(MODE_WR_LV, $urandom_range(0, n_codes - 1), rand24());
			end else if (r >= 96) begin
				case ($urandom_range(0, 2))
					0: send_word(MODE_UNUSED, $urandom_range(0, IDX_TOP), rand24());
					1: send_word(MODE_WR_TH, $urandom_range(TH_LAST + 1, IDX_TOP), rand24());
					default: send_word(MODE_WR_LV, $urandom_range(TH_LAST, IDX_TOP), rand24());
				endcase
			end else begin
				send_word(MODE_SAMPLE, $urandom_range(0, IDX_TOP), pick_sample());
				done++;
			end
			if ($urandom_range(0, 79) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk) res_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				stall = calm ? 0 : $urandom_range(0, 3);
				if (stall > 0) begin
					@(negedge clk) res_ch.ready <= 1'b0;
					repeat (stall - 1) @(negedge clk);
					@(negedge clk) res_ch.ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_SAMPLE;
		item_ch.index = '0;
		item_ch.value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_BITS;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed words on a small ideal table: field extremes, clipping, both table ends,
		// the snap window edges, and the write words that must be dropped.
		configure(4, 0, 4194304, 1, 1000, SHAPE_UNIFORM);
		send_word(MODE_SAMPLE, 0, VAL_MIN);
		send_word(MODE_SAMPLE, IDX_TOP, VAL_MAX);
		send_word(MODE_SAMPLE, 0, -vref_now);
		send_word(MODE_SAMPLE, 0, vref_now);
		send_word(MODE_SAMPLE, 0, th_shadow[0]);
		send_word(MODE_SAMPLE, 0, th_shadow[0] + 1);
		send_word(MODE_SAMPLE, 0, th_shadow[16]);
		send_word(MODE_SAMPLE, 0, th_shadow[16] - 1);
		send_word(MODE_SAMPLE, 0, th_shadow[5]);
		send_word(MODE_SAMPLE, 0, th_shadow[5] - 1);
		send_word(MODE_SAMPLE, 0, th_shadow[5] - tol_now);
		send_word(MODE_SAMPLE, 0, th_shadow[5] - tol_now - 1);
		send_word(MODE_SAMPLE, 0, 0);
		send_word(MODE_UNUSED, IDX_TOP, VAL_MIN);
		send_word(MODE_WR_TH, TH_LAST + 1, VAL_MAX);
		send_word(MODE_WR_TH, IDX_TOP, 0);
		send_word(MODE_WR_LV, TH_LAST, rand24());
		send_word(MODE_WR_LV, IDX_TOP, rand24());
		send_word(MODE_WR_TH, TH_LAST, rand24());
		send_word(MODE_SAMPLE, 0, th_shadow[3] + 7);
		drain();

		configure(4, 1, 8388607, 1, 0, SHAPE_RAGGED);
		random_words(60, 1'b1);
		configure(5, 0, 1, 1, 8388607, SHAPE_UNIFORM);
		random_words(40, 1'b1);
		configure(6, 1, 300000, 1, 5000, SHAPE_SCRAMBLED);
		random_words(40, 1'b1);
		configure(0, 0, 8388607, 0, 164, SHAPE_SCRAMBLED);
		random_words(40, 1'b1);
		configure(7, 0, $urandom_range(1, 8388607), 1, $urandom_range(0, 100000), SHAPE_RAGGED);
		random_words(30, 1'b1);
		configure(4, 1, $urandom_range(1, 8388607), 1, $urandom_range(0, 300000),
			SHAPE_SCRAMBLED);
		random_words(50, 1'b1);

		if (bad_words == 0 && codes_waiting == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
